@@ hdl/hee_pkg.sv @@
// ----------------------------------------------------------------------------
// hee_pkg: shared types and helpers for the HTML entity escaper
// Item kinds passed from the classifier to the emitter, queue entry type,
// and the lookup functions that spell out each escape run.
// ----------------------------------------------------------------------------
package hee_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int RUN_IDX_W   = 3;   // runs are at most six bytes

    typedef enum logic [3:0] {
        KIND_PASS,
        KIND_LT,
        KIND_GT,
        KIND_AMP,
        KIND_QUOT,
        KIND_APOS,
        KIND_DASH,
        KIND_BSL,
        KIND_HEX
    } esc_kind_t;

    typedef struct packed {
        esc_kind_t  kind;
        logic [7:0] data;
    } esc_item_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10)
            ch = 8'(8'h30 + {4'b0, d});
        else
            ch = 8'(8'h57 + {4'b0, d});   // 'a' - 10
        return ch;
    endfunction

    function automatic logic [RUN_IDX_W-1:0] run_len(input esc_item_t it);
        logic [RUN_IDX_W-1:0] n;
        case (it.kind)
            KIND_PASS: n = RUN_IDX_W'(1);
            KIND_BSL:  n = RUN_IDX_W'(2);
            KIND_LT:   n = RUN_IDX_W'(4);
            KIND_GT:   n = RUN_IDX_W'(4);
            KIND_AMP:  n = RUN_IDX_W'(5);
            KIND_DASH: n = RUN_IDX_W'(5);
            KIND_QUOT: n = RUN_IDX_W'(6);
            KIND_APOS: n = RUN_IDX_W'(6);
            KIND_HEX:  n = (it.data[7:4] != 4'd0) ? RUN_IDX_W'(6) : RUN_IDX_W'(5);
            default:   n = RUN_IDX_W'(1);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] run_char(input esc_item_t it,
                                            input logic [RUN_IDX_W-1:0] idx);
        logic [7:0] ch;
        logic       hi_nz;
        hi_nz = (it.data[7:4] != 4'd0);
        ch    = "&";
        case (it.kind) inside
            KIND_PASS: ch = it.data;
            KIND_BSL:  ch = "\\";
            KIND_LT, KIND_GT:
            begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = (it.kind == KIND_LT) ? "l" : "g";
                    3'd2:    ch = "t";
                    default: ch = ";";
                endcase
            end
            KIND_AMP:
            begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "a";
                    3'd2:    ch = "m";
                    3'd3:    ch = "p";
                    default: ch = ";";
                endcase
            end
            KIND_QUOT:
            begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "q";
                    3'd2:    ch = "u";
                    3'd3:    ch = "o";
                    3'd4:    ch = "t";
                    default: ch = ";";
                endcase
            end
            KIND_APOS:
            begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "a";
                    3'd2:    ch = "p";
                    3'd3:    ch = "o";
                    3'd4:    ch = "s";
                    default: ch = ";";
                endcase
            end
            KIND_DASH:
            begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "#";
                    3'd2:    ch = "4";
                    3'd3:    ch = "5";
                    default: ch = ";";
                endcase
            end
            KIND_HEX:
            begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "#";
                    3'd2:    ch = "x";
                    3'd3:    ch = hi_nz ? hex_digit(it.data[7:4]) : hex_digit(it.data[3:0]);
                    3'd4:    ch = hi_nz ? hex_digit(it.data[3:0]) : ";";
                    default: ch = ";";
                endcase
            end
            default: ch = it.data;
        endcase
        return ch;
    endfunction

endpackage

@@ hdl/html_entity_escaper.sv @@
// ----------------------------------------------------------------------------
// html_entity_escaper: streaming HTML escape of a byte stream
// Input channel (in_valid/in_stall): one text byte per request plus a
// start_of_text flag that clears the dash history. Output channel
// (out_valid/out_stall): one 7-bit ASCII byte per request, last_of_run high on
// the final byte produced for an input byte. Runs are 1 to 6 bytes.
// The first byte of a run passes through the queue entry and then the output
// register. Throughput: one output byte per cycle unless out_stall holds the
// output, so plain bytes pass at one per cycle; an input byte that expands
// to a longer run holds the emitter until its last byte. A 4-entry item queue
// sits between classifier and emitter; in_stall rises only while it is full.
// cfg_wr_en/cfg_wr_data write the backslash-doubling mode (1 after reset).
// Reset empties the queue, drops any pending output byte and clears the dash
// history. While out_stall holds a valid output byte, that byte holds and the
// emitter waits; the classifier keeps taking requests until the queue fills.
// ----------------------------------------------------------------------------
module html_entity_escaper
#(
    parameter int QUEUE_DEPTH = hee_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       start_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] out_byte,
    output logic       last_of_run,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               head_valid;
    hee_pkg::esc_item_t push_item;
    hee_pkg::esc_item_t head_item;

    hee_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .start_of_text (start_of_text),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    hee_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    hee_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

@@ hdl/hee_front.sv @@
// ----------------------------------------------------------------------------
// hee_front: input classifier
// Takes requests from the input channel, tracks the dash history and the
// backslash mode, and pushes a tagged item into the queue.
// ----------------------------------------------------------------------------
module hee_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic              start_of_text,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              q_full,
    output logic              q_push,
    output hee_pkg::esc_item_t q_item
);

    logic dbl_bsl_reg;
    logic prior_dash_reg;
    logic prior_dash_next;
    logic dash_seen;

    assign in_stall  = q_full;
    assign q_push    = in_valid && !q_full;
    assign dash_seen = prior_dash_reg && !start_of_text;

    always_comb
    begin
        q_item.data = in_byte;
        if (in_byte == "<")
            q_item.kind = hee_pkg::KIND_LT;
        else if (in_byte == ">")
            q_item.kind = hee_pkg::KIND_GT;
        else if (in_byte == "\\" && dbl_bsl_reg)
            q_item.kind = hee_pkg::KIND_BSL;
        else if (in_byte == "&")
            q_item.kind = hee_pkg::KIND_AMP;
        else if (in_byte == "\"")
            q_item.kind = hee_pkg::KIND_QUOT;
        else if (in_byte == "'")
            q_item.kind = hee_pkg::KIND_APOS;
        else if (in_byte == "-" && dash_seen)
            q_item.kind = hee_pkg::KIND_DASH;
        else if (in_byte < 8'h20 || in_byte > 8'h7f)
            q_item.kind = hee_pkg::KIND_HEX;
        else
            q_item.kind = hee_pkg::KIND_PASS;
    end

    // history follows the input byte, not what gets emitted
    assign prior_dash_next = q_push ? (in_byte == "-") : prior_dash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbl_bsl_reg    <= 1'b1;
            prior_dash_reg <= 1'b0;
        end
        else
        begin
            prior_dash_reg <= prior_dash_next;
            if (cfg_wr_en)
                dbl_bsl_reg <= cfg_wr_data;
        end
    end

endmodule

@@ hdl/hee_fifo.sv @@
// ----------------------------------------------------------------------------
// hee_fifo: item queue between classifier and emitter
// Small register queue; head entry is visible without a pop.
// ----------------------------------------------------------------------------
module hee_fifo
#(
    parameter int DEPTH = hee_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hee_pkg::esc_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output hee_pkg::esc_item_t head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hee_pkg::esc_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != CW'(0));
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : PW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : PW'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            count_next = CW'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |=> count_reg == CW'(DEPTH))
        else $error("push into full queue changed count");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'(0) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");

endmodule

@@ hdl/hee_back.sv @@
// ----------------------------------------------------------------------------
// hee_back: run emitter
// Walks the head item byte by byte into the output register and pops it
// after its last byte.
// ----------------------------------------------------------------------------
module hee_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  hee_pkg::esc_item_t head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [6:0]         out_byte,
    output logic               last_of_run
);

    localparam int IW = hee_pkg::RUN_IDX_W;

    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] len;
    logic [7:0]    ch;
    logic          emit;
    logic          at_last;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    out_byte_reg;
    logic          last_reg;

    assign len     = hee_pkg::run_len(head_item);
    assign ch      = hee_pkg::run_char(head_item, idx_reg);
    assign at_last = (idx_reg == IW'(len - 1'b1));
    assign emit    = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = emit && at_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = at_last ? IW'(0) : IW'(idx_reg + 1'b1);
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= ch[6:0];
            last_reg     <= at_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < len)
        else $error("run index past run length");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == IW'(0))
        else $error("run index left over with no item");

    a_pop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == IW'(0) && out_valid_reg && last_reg)
        else $error("item popped without closing its run");

endmodule
